[hw/rtl/tpq_pkg.sv]
// Shared constants for the two-level priority queue: field widths, operation and status codes.
package tpq_pkg;

    localparam int unsigned ID_W     = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            pri;
    } entry_t;

endpackage

[hw/rtl/tpq_if.sv]
// Request and response channel interfaces of the two-level priority queue.
interface tpq_req_if;
    logic                        valid;
    logic                        ready;
    logic [tpq_pkg::MODE_W-1:0]  mode;
    logic [tpq_pkg::ID_W-1:0]    entry_id;
    logic                        entry_priority;

    modport source (output valid, output mode, output entry_id, output entry_priority,
                    input ready);
    modport sink   (input valid, input mode, input entry_id, input entry_priority,
                    output ready);
endinterface

interface tpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tpq_pkg::STATUS_W-1:0]  status;
    logic [tpq_pkg::ID_W-1:0]      popped_id;
    logic                          popped_priority;
    logic [tpq_pkg::COUNT_W-1:0]   entry_count;
    logic [tpq_pkg::COUNT_W-1:0]   high_count;

    modport source (output valid, output status, output popped_id, output popped_priority,
                    output entry_count, output high_count, input ready);
    modport sink   (input valid, input status, input popped_id, input popped_priority,
                    input entry_count, input high_count, output ready);
endinterface

[hw/rtl/two_level_priority_queue.sv]
// Two-level priority queue: circular entry memory walked by a small sequencer.
// Append, low-priority or empty-queue insert, reject, empty pop and unused code go to S_DONE and
// then load the response register; a pop reads the head and passes through S_POP; a priority
// insert walks S_WALK, moving one entry back per step, and S_PLACE if it reaches the head.
// The next request waits for an idle sequencer; a stalled response holds it in S_DONE longer.
// Reset clears indexes, counts and handshake state; the entry memory is left as it is.
module two_level_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tpq_req_if.sink    req,
    tpq_rsp_if.source  rsp
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
        prev_slot = (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    // control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  walk_reg, walk_next;     // slot whose entry sits in rd_data_reg
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  high_reg, high_next;
    logic [CNT_W-1:0]  left_reg, left_next;     // entries still to examine in the walk
    logic              out_valid_reg, out_valid_next;

    // payload held for the operation in flight
    logic [tpq_pkg::ID_W-1:0]      op_id_reg, op_id_next;
    logic                          op_pri_reg, op_pri_next;
    logic [tpq_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [tpq_pkg::ID_W-1:0]      res_id_reg, res_id_next;
    logic                          res_pri_reg, res_pri_next;
    logic [tpq_pkg::COUNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic [tpq_pkg::COUNT_W-1:0]   res_high_reg, res_high_next;

    // response register
    logic [tpq_pkg::STATUS_W-1:0]  out_status_reg;
    logic [tpq_pkg::ID_W-1:0]      out_id_reg;
    logic                          out_pri_reg;
    logic [tpq_pkg::COUNT_W-1:0]   out_cnt_reg;
    logic [tpq_pkg::COUNT_W-1:0]   out_high_reg;

    // entry memory, one write and one registered read port
    tpq_pkg::entry_t   mem [DEPTH];
    tpq_pkg::entry_t   rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    tpq_pkg::entry_t   wr_data;

    logic full;
    logic out_free;
    logic out_load;

    assign full     = (occ_reg == FULL_CNT);
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == S_DONE) && out_free;

    // Requests are taken whenever the sequencer is idle, even with a response still waiting.
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        walk_next       = walk_reg;
        occ_next        = occ_reg;
        high_next       = high_reg;
        left_next       = left_reg;
        op_id_next      = op_id_reg;
        op_pri_next     = op_pri_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_pri_next    = res_pri_reg;
        res_cnt_next    = res_cnt_reg;
        res_high_next   = res_high_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = next_slot(walk_reg);
        wr_data         = '{id: op_id_reg, pri: op_pri_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_id_next      = req.entry_id;
                    op_pri_next     = req.entry_priority;
                    res_status_next = tpq_pkg::STATUS_DONE;
                    res_id_next     = '0;
                    res_pri_next    = 1'b0;
                    res_cnt_next    = tpq_pkg::COUNT_W'(occ_reg);
                    res_high_next   = tpq_pkg::COUNT_W'(high_reg);
                    state_next      = S_DONE;
                    if (req.mode == tpq_pkg::MODE_APPEND || req.mode == tpq_pkg::MODE_INSERT)
                    begin
                        if (full)
                        begin
                            res_status_next = tpq_pkg::STATUS_FULL;
                        end
                        else if (req.mode == tpq_pkg::MODE_INSERT && req.entry_priority
                                 && occ_reg != '0)
                        begin
                            // start the walk from the newest entry toward the head
                            walk_next  = prev_slot(tail_reg);
                            rd_en      = 1'b1;
                            rd_addr    = prev_slot(tail_reg);
                            left_next  = occ_reg;
                            state_next = S_WALK;
                        end
                        else
                        begin
                            // low-priority inserts and inserts into an empty queue go to the tail as appends
                            wr_en         = 1'b1;
                            wr_addr       = tail_reg;
                            wr_data       = '{id: req.entry_id, pri: req.entry_priority};
                            tail_next     = next_slot(tail_reg);
                            occ_next      = occ_reg + CNT_W'(1);
                            high_next     = high_reg + CNT_W'(req.entry_priority);
                            res_cnt_next  = tpq_pkg::COUNT_W'(occ_next);
                            res_high_next = tpq_pkg::COUNT_W'(high_next);
                        end
                    end
                    else if (req.mode == tpq_pkg::MODE_POP)
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = tpq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_WALK:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.pri)
                begin
                    // equal priority found: drop the new entry right behind it
                    tail_next     = next_slot(tail_reg);
                    occ_next      = occ_reg + CNT_W'(1);
                    high_next     = high_reg + CNT_W'(1);
                    res_cnt_next  = tpq_pkg::COUNT_W'(occ_next);
                    res_high_next = tpq_pkg::COUNT_W'(high_next);
                    state_next    = S_DONE;
                end
                else
                begin
                    // move the low-priority entry back one slot and read the one before it while entries remain
                    wr_data   = rd_data_reg;
                    walk_next = prev_slot(walk_reg);
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = prev_slot(walk_reg);
                    end
                end
            end

            S_PLACE:
            begin
                // every stored entry was low priority: the new one becomes the head
                wr_en         = 1'b1;
                tail_next     = next_slot(tail_reg);
                occ_next      = occ_reg + CNT_W'(1);
                high_next     = high_reg + CNT_W'(1);
                res_cnt_next  = tpq_pkg::COUNT_W'(occ_next);
                res_high_next = tpq_pkg::COUNT_W'(high_next);
                state_next    = S_DONE;
            end

            S_POP:
            begin
                res_id_next  = rd_data_reg.id;
                res_pri_next = rd_data_reg.pri;
                head_next    = next_slot(head_reg);
                occ_next     = occ_reg - CNT_W'(1);
                if (rd_data_reg.pri && high_reg != '0)
                begin
                    high_next = high_reg - CNT_W'(1);
                end
                res_cnt_next  = tpq_pkg::COUNT_W'(occ_next);
                res_high_next = tpq_pkg::COUNT_W'(high_next);
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // hold the result until the response register is free
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            walk_reg      <= '0;
            occ_reg       <= '0;
            high_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            walk_reg      <= walk_next;
            occ_reg       <= occ_next;
            high_reg      <= high_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_id_reg      <= op_id_next;
        op_pri_reg     <= op_pri_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_pri_reg    <= res_pri_next;
        res_cnt_reg    <= res_cnt_next;
        res_high_reg   <= res_high_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_pri_reg    <= res_pri_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_high_reg   <= res_high_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.popped_id       = out_id_reg;
    assign rsp.popped_priority = out_pri_reg;
    assign rsp.entry_count     = out_cnt_reg;
    assign rsp.high_count      = out_high_reg;

    // Occupancy never runs past the memory depth.
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= FULL_CNT)
        else $error("occupancy above depth");

    // High-priority count never exceeds the total count.
    assert property (@(posedge clk) disable iff (!rst_n) high_reg <= occ_reg)
        else $error("high-priority count above occupancy");

    // A walk only runs with entries left to examine and a free slot for the insert.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_WALK) |-> (left_reg != '0 && !full))
        else $error("insert walk without room or entries");

    // The response register is only overwritten once its transaction has completed.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_id_reg)))
        else $error("pending response lost");

endmodule
